@@ design/pli_pkg.sv @@
// Shared types and constants for the posting list intersection block.
// Used by pli_front, pli_back and the top level; depends on nothing.
package pli_pkg;

	localparam int DOC_W = 12;
	localparam int CNT_W = 8;
	localparam int MODE_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Input mode codes
	localparam logic [MODE_W-1:0] MODE_POST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FETCH = 2'd2;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPW = 2;

	typedef enum logic [1:0] {
		OP_POST,
		OP_CLOSE,
		OP_FETCH
	} op_t;

	// Head of the queue as seen by the back end
	typedef struct packed {
		logic vld;
		op_t  op;
	} head_t;

endpackage

@@ design/pli_front.sv @@
// Front end: takes input words, drops ignored ones, queues operations.
// Depends on pli_pkg.
module pli_front #(
	parameter int DOC_SLOTS = 4096,
	localparam int AW = $clog2(DOC_SLOTS)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pli_pkg::MODE_W-1:0]     mode,
	input  logic [pli_pkg::DOC_W-1:0]      doc_id,
	output pli_pkg::head_t                 head,
	output logic [AW-1:0]                  head_addr,
	input  logic                           head_pop
);

	pli_pkg::op_t      q_op_q   [pli_pkg::QDEPTH];
	logic [AW-1:0]     q_addr_q [pli_pkg::QDEPTH];
	logic [pli_pkg::QPW-1:0] wr_q, rd_q;
	logic [pli_pkg::QPW:0]   cnt_q;

	logic          keep;
	logic          push;
	logic          in_range;
	pli_pkg::op_t  op_in;

	assign in_ready = (cnt_q != (pli_pkg::QPW+1)'(pli_pkg::QDEPTH));
	assign in_range = (32'(doc_id) < 32'(DOC_SLOTS));

	// Classify: postings out of range and the unused mode are dropped
	always_comb begin
		unique case (mode)
			pli_pkg::MODE_POST: begin
				op_in = pli_pkg::OP_POST;
				keep  = in_range;
			end
			pli_pkg::MODE_CLOSE: begin
				op_in = pli_pkg::OP_CLOSE;
				keep  = 1'b1;
			end
			pli_pkg::MODE_FETCH: begin
				op_in = pli_pkg::OP_FETCH;
				keep  = 1'b1;
			end
			default: begin
				op_in = pli_pkg::OP_CLOSE;
				keep  = 1'b0;
			end
		endcase
	end

	assign push = in_valid && in_ready && keep;

	assign head.vld  = (cnt_q != '0);
	assign head.op   = q_op_q[rd_q];
	assign head_addr = q_addr_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_op_q[wr_q]   <= op_in;
			q_addr_q[wr_q] <= AW'(doc_id);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (head_pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (pli_pkg::QPW+1)'(push) - (pli_pkg::QPW+1)'(head_pop);
		end
	end

endmodule

@@ design/pli_back.sv @@
// Back end: counter store, posting read-modify-write, candidate scan and
// clearing sweep, plus the result register. Depends on pli_pkg.
module pli_back #(
	parameter int DOC_SLOTS = 4096,
	localparam int AW = $clog2(DOC_SLOTS),
	localparam int PW = AW + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pli_pkg::head_t                head,
	input  logic [AW-1:0]                 head_addr,
	output logic                          head_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pli_pkg::DOC_W-1:0]     doc_id_res,
	output logic [pli_pkg::CNT_W-1:0]     matched_terms,
	output logic                          done_res
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN,
		ST_SCAN
	} state_t;

	state_t state_q;

	logic [pli_pkg::CNT_W-1:0] mem [DOC_SLOTS];
	logic [pli_pkg::CNT_W-1:0] rd_data_q;

	logic          vld_s2;
	logic [AW-1:0] addr_s2;

	logic                      wr_vld_q;
	logic [AW-1:0]             wr_addr_q;
	logic [pli_pkg::CNT_W-1:0] wr_data_q;

	logic [AW-1:0]             clr_q;
	logic [PW-1:0]             scan_pos_q;
	logic [PW-1:0]             iss_q;
	logic [pli_pkg::CNT_W-1:0] lists_q;

	logic                      out_vld_q;
	logic [pli_pkg::DOC_W-1:0] res_id_q;
	logic [pli_pkg::CNT_W-1:0] res_cnt_q;
	logic                      res_done_q;

	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [pli_pkg::CNT_W-1:0] mem_wdata;
	logic [AW-1:0]             mem_raddr;
	logic [pli_pkg::CNT_W-1:0] cur_cnt;
	logic                      out_free;
	logic                      hit;
	logic                      iss_more;
	logic                      scan_issue;
	logic                      scan_done;
	logic                      post_go;

	// Bypass the write made in the previous cycle; the read register missed it
	assign cur_cnt = (wr_vld_q && wr_addr_q == addr_s2) ? wr_data_q : rd_data_q;

	assign out_free = !out_vld_q || out_ready;
	assign hit      = (state_q == ST_SCAN) && vld_s2 && (cur_cnt != '0) && (cur_cnt == lists_q);
	assign iss_more = (iss_q < PW'(DOC_SLOTS));
	assign scan_issue = (state_q == ST_SCAN) && !hit && iss_more;
	assign scan_done  = (state_q == ST_SCAN) && !hit && !iss_more;

	assign head_pop = (state_q == ST_RUN) && head.vld
		&& (head.op != pli_pkg::OP_FETCH || out_free);
	assign post_go  = head_pop && (head.op == pli_pkg::OP_POST);

	assign mem_raddr = (state_q == ST_SCAN) ? iss_q[AW-1:0] : head_addr;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s2;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_RUN: begin
				mem_we    = vld_s2;
				mem_wdata = (cur_cnt == pli_pkg::CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
			end
			ST_SCAN: begin
				// clear each entry the scan passes
				mem_we = vld_s2;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_data_q <= mem[mem_raddr];
		wr_addr_q <= mem_waddr;
		wr_data_q <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			res_id_q   <= pli_pkg::DOC_W'(addr_s2);
			res_cnt_q  <= cur_cnt;
			res_done_q <= 1'b0;
		end else if (scan_done) begin
			res_id_q   <= '0;
			res_cnt_q  <= '0;
			res_done_q <= 1'b1;
		end
		if (post_go || scan_issue)
			addr_s2 <= post_go ? head_addr : iss_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			vld_s2     <= 1'b0;
			wr_vld_q   <= 1'b0;
			clr_q      <= '0;
			scan_pos_q <= '0;
			iss_q      <= '0;
			lists_q    <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			wr_vld_q <= mem_we;
			if (hit || scan_done)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;

			unique case (state_q)
				ST_CLEAR: begin
					vld_s2 <= 1'b0;
					if (clr_q == AW'(DOC_SLOTS - 1)) begin
						clr_q   <= '0;
						state_q <= ST_RUN;
					end else
						clr_q <= clr_q + 1'b1;
				end
				ST_RUN: begin
					vld_s2 <= post_go;
					if (head_pop && head.op == pli_pkg::OP_CLOSE
						&& lists_q != pli_pkg::CNT_MAX)
						lists_q <= lists_q + 1'b1;
					if (head_pop && head.op == pli_pkg::OP_FETCH) begin
						iss_q   <= scan_pos_q;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					vld_s2 <= scan_issue;
					if (scan_issue)
						iss_q <= iss_q + 1'b1;
					if (scan_done) begin
						// end of query: reset and sweep the whole store
						scan_pos_q <= '0;
						lists_q    <= '0;
						state_q    <= ST_CLEAR;
					end else begin
						if (vld_s2)
							scan_pos_q <= {1'b0, addr_s2} + PW'(1);
						if (hit)
							state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign out_valid     = out_vld_q;
	assign doc_id_res    = res_id_q;
	assign matched_terms = res_cnt_q;
	assign done_res      = res_done_q;

endmodule

@@ design/posting_list_and_intersection.sv @@
// AND intersection of one query's posting lists by per-document counting.
// Input channel (in_valid/in_ready, mode, doc_id): mode 0 adds one posting to
// the counter of doc_id (saturating at 255, ids beyond the store dropped),
// mode 1 closes one term list, mode 2 fetches the next candidate, mode 3 is
// dropped. Output channel (out_valid/out_ready): one word per fetch, either a
// document id with its count, or done_res set with id and count zero.
// Words enter a four-entry queue; the back end drains it independently.
// Postings run through a read/modify/write on the counter memory at one per
// cycle while no scan or sweep runs, with a bypass of the last write.
// A fetch examines one counter per cycle, clearing each, until a hit or the
// end of the store; then its result is registered. A fetch waits in the
// queue until the result register is free.
// A done result is followed by a clearing sweep over the whole counter
// memory, one entry per cycle; the same sweep runs after reset. During
// a sweep the queue still fills, then in_ready drops until the sweep ends.
// A stalled receiver holds the result; postings and closes keep flowing.
// Depends on pli_pkg, pli_front and pli_back.
module posting_list_and_intersection #(
	parameter int DOC_SLOTS = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pli_pkg::MODE_W-1:0]    mode,
	input  logic [pli_pkg::DOC_W-1:0]     doc_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pli_pkg::DOC_W-1:0]     doc_id_res,
	output logic [pli_pkg::CNT_W-1:0]     matched_terms,
	output logic                          done_res
);

	localparam int AW = $clog2(DOC_SLOTS);

	pli_pkg::head_t head;
	logic [AW-1:0]  head_addr;
	logic           head_pop;

	pli_front #(
		.DOC_SLOTS(DOC_SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.doc_id   (doc_id),
		.head     (head),
		.head_addr(head_addr),
		.head_pop (head_pop)
	);

	pli_back #(
		.DOC_SLOTS(DOC_SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_addr    (head_addr),
		.head_pop     (head_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.doc_id_res   (doc_id_res),
		.matched_terms(matched_terms),
		.done_res     (done_res)
	);

endmodule
